// File: rtl/idll_pkg.sv
`timescale 1ns / 1ps

package idll_pkg;

	// slot index width, slot count and stored data width
	localparam int SLOT_W      = 6;
	localparam int SLOTS       = 1 << SLOT_W;
	localparam int DATA_BITS   = 32;
	localparam int COUNT_W     = 6;

	// stream payload widths
	localparam int IN_TDATA_W  = 40;
	localparam int RES_W       = 2 + SLOT_W + DATA_BITS + SLOT_W + SLOT_W + COUNT_W;
	localparam int OUT_TDATA_W = 64;

	typedef logic [SLOT_W-1:0]    slot_t;
	typedef logic [DATA_BITS-1:0] data_t;
	typedef logic [COUNT_W-1:0]   count_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_BAD_SLOT = 2'd2
	} status_t;

	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_DELETE = 1'b1
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_A,
		ST_INS_B,
		ST_INS_C,
		ST_DEL_A,
		ST_DEL_B,
		ST_ERR
	} state_t;

	typedef struct packed {
		logic  we;
		slot_t addr;
		slot_t data;
	} link_wr_t;

	typedef struct packed {
		logic  we;
		slot_t addr;
		data_t data;
	} data_wr_t;

	// control from the sequencer to the slot store
	typedef struct packed {
		link_wr_t nl_wr;
		link_wr_t pl_wr;
		data_wr_t vs_wr;
		slot_t    nl_raddr;
		slot_t    pl_raddr;
		slot_t    vs_raddr;
	} store_req_t;

	// registered read data from the slot store
	typedef struct packed {
		slot_t nl;
		slot_t pl;
		data_t vs;
	} store_rd_t;

	typedef struct packed {
		status_t status;
		slot_t   new_slot;
		data_t   value_out;
		slot_t   head_slot;
		slot_t   tail_slot;
		count_t  count;
	} result_t;

endpackage

// File: rtl/idll_ram.sv
`timescale 1ns / 1ps

module idll_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/idll_store.sv
`timescale 1ns / 1ps

module idll_store (
	input  logic                clk,
	input  logic                arst_n,
	input  idll_pkg::store_req_t req,
	output idll_pkg::store_rd_t  rd
);

	// written flags stand in for the reset contents of the link memories
	logic [idll_pkg::SLOTS-1:0] nl_vld_q;
	logic [idll_pkg::SLOTS-1:0] pl_vld_q;
	logic                       nl_vld_s1;
	logic                       pl_vld_s1;
	idll_pkg::slot_t            nl_raddr_s1;
	idll_pkg::slot_t            nl_ram;
	idll_pkg::slot_t            pl_ram;
	idll_pkg::data_t            vs_ram;

	idll_ram #(.WIDTH(idll_pkg::SLOT_W), .DEPTH(idll_pkg::SLOTS)) u_next (
		.clk   (clk),
		.we    (req.nl_wr.we),
		.waddr (req.nl_wr.addr),
		.wdata (req.nl_wr.data),
		.raddr (req.nl_raddr),
		.rdata (nl_ram)
	);

	idll_ram #(.WIDTH(idll_pkg::SLOT_W), .DEPTH(idll_pkg::SLOTS)) u_prev (
		.clk   (clk),
		.we    (req.pl_wr.we),
		.waddr (req.pl_wr.addr),
		.wdata (req.pl_wr.data),
		.raddr (req.pl_raddr),
		.rdata (pl_ram)
	);

	idll_ram #(.WIDTH(idll_pkg::DATA_BITS), .DEPTH(idll_pkg::SLOTS)) u_value (
		.clk   (clk),
		.we    (req.vs_wr.we),
		.waddr (req.vs_wr.addr),
		.wdata (req.vs_wr.data),
		.raddr (req.vs_raddr),
		.rdata (vs_ram)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nl_vld_q  <= '0;
			pl_vld_q  <= '0;
			nl_vld_s1 <= 1'b0;
			pl_vld_s1 <= 1'b0;
		end else begin
			if (req.nl_wr.we) begin
				nl_vld_q[req.nl_wr.addr] <= 1'b1;
			end
			if (req.pl_wr.we) begin
				pl_vld_q[req.pl_wr.addr] <= 1'b1;
			end
			nl_vld_s1 <= nl_vld_q[req.nl_raddr];
			pl_vld_s1 <= pl_vld_q[req.pl_raddr];
		end
	end

	always_ff @(posedge clk) begin
		nl_raddr_s1 <= req.nl_raddr;
	end

	// unwritten next link: sentinel points at itself, free slots chain upward
	always_comb begin
		if (nl_vld_s1) begin
			rd.nl = nl_ram;
		end else if (nl_raddr_s1 == '0) begin
			rd.nl = '0;
		end else begin
			rd.nl = idll_pkg::slot_t'(nl_raddr_s1 + 1'b1);
		end
		rd.pl = pl_vld_s1 ? pl_ram : '0;
		rd.vs = vs_ram;
	end

endmodule

// File: rtl/idll_ctrl.sv
`timescale 1ns / 1ps

module idll_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  idll_pkg::req_t       req_type,
	input  idll_pkg::slot_t      slot_index,
	input  idll_pkg::data_t      value_in,
	output idll_pkg::store_req_t sreq,
	input  idll_pkg::store_rd_t  rd,
	input  logic                 out_free,
	output logic                 res_valid,
	output idll_pkg::result_t    res
);

	idll_pkg::state_t           state_q;
	idll_pkg::state_t           state_d;
	idll_pkg::slot_t            idx_q;
	idll_pkg::slot_t            slot_q;
	idll_pkg::data_t            val_q;
	idll_pkg::data_t            value_q;
	idll_pkg::status_t          status_q;
	idll_pkg::slot_t            free_head_q;
	idll_pkg::count_t           count_q;
	idll_pkg::slot_t            head_q;
	idll_pkg::slot_t            tail_q;
	logic [idll_pkg::SLOTS-1:0] in_use_q;
	logic                       used_s1;
	logic                       accept;
	logic                       bad_slot;
	logic                       full;
	logic                       reject;
	logic                       res_load;
	idll_pkg::slot_t            head_d;
	idll_pkg::slot_t            tail_d;
	idll_pkg::slot_t            new_slot_d;
	idll_pkg::data_t            value_out_d;
	idll_pkg::count_t           count_d;

	// slot checks use the registered in-use flag, valid in the first busy state
	assign accept   = in_valid && in_ready;
	assign bad_slot = !used_s1 || (state_q == idll_pkg::ST_DEL_A && idx_q == '0);
	assign full     = (state_q == idll_pkg::ST_INS_A) && (free_head_q == '0);
	assign reject   = bad_slot || full;
	assign res_load = res_valid && out_free;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			idll_pkg::ST_IDLE: begin
				if (accept) begin
					if (req_type == idll_pkg::REQ_INSERT) begin
						state_d = idll_pkg::ST_INS_A;
					end else begin
						state_d = idll_pkg::ST_DEL_A;
					end
				end
			end
			idll_pkg::ST_INS_A: begin
				state_d = reject ? idll_pkg::ST_ERR : idll_pkg::ST_INS_B;
			end
			idll_pkg::ST_INS_B: state_d = idll_pkg::ST_INS_C;
			idll_pkg::ST_DEL_A: begin
				state_d = reject ? idll_pkg::ST_ERR : idll_pkg::ST_DEL_B;
			end
			idll_pkg::ST_INS_C,
			idll_pkg::ST_DEL_B,
			idll_pkg::ST_ERR: begin
				if (out_free) begin
					state_d = idll_pkg::ST_IDLE;
				end
			end
			default: state_d = idll_pkg::ST_IDLE;
		endcase
	end

	// memory ports and result
	always_comb begin
		in_ready      = 1'b0;
		res_valid     = 1'b0;
		sreq          = '0;
		sreq.nl_raddr = idx_q;
		sreq.pl_raddr = slot_index;
		sreq.vs_raddr = slot_index;
		new_slot_d    = '0;
		value_out_d   = '0;
		count_d       = count_q;
		unique case (state_q)
			idll_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				sreq.nl_raddr = (req_type == idll_pkg::REQ_INSERT) ? free_head_q : slot_index;
			end
			idll_pkg::ST_INS_A: begin
				// value and back link of the new slot
				if (!reject) begin
					sreq.vs_wr.we   = 1'b1;
					sreq.vs_wr.addr = slot_q;
					sreq.vs_wr.data = val_q;
					sreq.pl_wr.we   = 1'b1;
					sreq.pl_wr.addr = slot_q;
					sreq.pl_wr.data = idx_q;
				end
			end
			idll_pkg::ST_INS_B: begin
				// rd.nl is the old successor of the anchor slot
				sreq.nl_wr.we   = 1'b1;
				sreq.nl_wr.addr = slot_q;
				sreq.nl_wr.data = rd.nl;
				sreq.pl_wr.we   = 1'b1;
				sreq.pl_wr.addr = rd.nl;
				sreq.pl_wr.data = slot_q;
			end
			idll_pkg::ST_INS_C: begin
				sreq.nl_wr.we   = 1'b1;
				sreq.nl_wr.addr = idx_q;
				sreq.nl_wr.data = slot_q;
				res_valid       = 1'b1;
				new_slot_d      = slot_q;
				count_d         = idll_pkg::count_t'(count_q + 1'b1);
			end
			idll_pkg::ST_DEL_A: begin
				// bridge the neighbours around the removed slot
				if (!reject) begin
					sreq.nl_wr.we   = 1'b1;
					sreq.nl_wr.addr = rd.pl;
					sreq.nl_wr.data = rd.nl;
					sreq.pl_wr.we   = 1'b1;
					sreq.pl_wr.addr = rd.nl;
					sreq.pl_wr.data = rd.pl;
				end
			end
			idll_pkg::ST_DEL_B: begin
				sreq.pl_wr.we   = 1'b1;
				sreq.pl_wr.addr = idx_q;
				sreq.pl_wr.data = '0;
				sreq.nl_wr.we   = 1'b1;
				sreq.nl_wr.addr = idx_q;
				sreq.nl_wr.data = free_head_q;
				res_valid       = 1'b1;
				value_out_d     = value_q;
				count_d         = idll_pkg::count_t'(count_q - 1'b1);
			end
			idll_pkg::ST_ERR: begin
				res_valid = 1'b1;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	// head and tail mirror the sentinel's links
	assign head_d = (sreq.nl_wr.we && sreq.nl_wr.addr == '0) ? sreq.nl_wr.data : head_q;
	assign tail_d = (sreq.pl_wr.we && sreq.pl_wr.addr == '0) ? sreq.pl_wr.data : tail_q;

	assign res = '{
		status:    status_q,
		new_slot:  new_slot_d,
		value_out: value_out_d,
		head_slot: head_d,
		tail_slot: tail_d,
		count:     count_d
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= idll_pkg::ST_IDLE;
			free_head_q <= idll_pkg::slot_t'(1);
			count_q     <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			in_use_q    <= {{(idll_pkg::SLOTS-1){1'b0}}, 1'b1};
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			if (state_q == idll_pkg::ST_INS_A && !reject) begin
				free_head_q      <= rd.nl;
				in_use_q[slot_q] <= 1'b1;
			end
			if (res_load) begin
				count_q <= count_d;
				if (state_q == idll_pkg::ST_DEL_B) begin
					free_head_q     <= idx_q;
					in_use_q[idx_q] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		used_s1 <= in_use_q[slot_index];
		if (accept) begin
			idx_q  <= slot_index;
			val_q  <= value_in;
			slot_q <= free_head_q;
		end
		if (state_q == idll_pkg::ST_INS_A || state_q == idll_pkg::ST_DEL_A) begin
			if (bad_slot) begin
				status_q <= idll_pkg::STAT_BAD_SLOT;
			end else if (full) begin
				status_q <= idll_pkg::STAT_FULL;
			end else begin
				status_q <= idll_pkg::STAT_OK;
			end
		end
		if (state_q == idll_pkg::ST_DEL_A) begin
			value_q <= rd.vs;
		end
	end

endmodule

// File: rtl/indexed_doubly_linked_list.sv
`timescale 1ns / 1ps

// channel   dir  tdata bits (low first)                                  tuser
// s_axis    in   slot_index 6, value_in 32, pad 2                         req_type 1
// m_axis    out  status 2, new_slot 6, value_out 32, head_slot 6,         none
//                tail_slot 6, count 6, pad 6
//
// one request at a time; a request is taken only in the idle state
// an insert steps through INS_A, INS_B and INS_C, a delete through DEL_A and
// DEL_B, a rejected request goes to ERR; the result is offered in the last of
// these, and the pace is set by the link memories, one synchronous read port each,
// the registered slot check and the chain of reads and writes on the memories
// reset clears control state at once; link memories come up through
// per-slot written flags, no clearing pass
// a full output register stalls the sequencer in its last state

module indexed_doubly_linked_list (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// slot_index, value_in, pad
	input  logic [idll_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// req_type
	input  logic                             s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// status, new_slot, value_out, head_slot, tail_slot, count, pad
	output logic [idll_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	idll_pkg::store_req_t             sreq;
	idll_pkg::store_rd_t              srd;
	idll_pkg::result_t                res;
	logic                             res_valid;
	logic                             out_free;
	logic                             out_load;
	logic                             m_valid_q;
	logic [idll_pkg::OUT_TDATA_W-1:0] m_data_q;

	// output register frees when empty or being drained
	assign out_free = !m_valid_q || m_axis_tready;
	assign out_load = res_valid && out_free;

	idll_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sreq),
		.rd     (srd)
	);

	idll_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.req_type   (idll_pkg::req_t'(s_axis_tuser)),
		.slot_index (s_axis_tdata[idll_pkg::SLOT_W-1:0]),
		.value_in   (s_axis_tdata[idll_pkg::SLOT_W +: idll_pkg::DATA_BITS]),
		.sreq       (sreq),
		.rd         (srd),
		.out_free   (out_free),
		.res_valid  (res_valid),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= {{(idll_pkg::OUT_TDATA_W - idll_pkg::RES_W){1'b0}},
			             res.count, res.tail_slot, res.head_slot,
			             res.value_out, res.new_slot, res.status};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// a request is never followed by another in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
	else $error("request accepted while sequencer busy");

	// a successful insert leaves a non-empty list with a head and a tail
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load && res.status == idll_pkg::STAT_OK && res.new_slot != '0
		|-> res.count != '0 && res.head_slot != '0 && res.tail_slot != '0)
	else $error("insert result shows an empty list");

	// an empty list has the sentinel as head and tail
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load && res.count == '0 |-> res.head_slot == '0 && res.tail_slot == '0)
	else $error("empty list with dangling head or tail");

endmodule
